>>> design/quoted_printable_encoder_defines.svh
// assertion macros shared by the encoder modules
`ifndef QUOTED_PRINTABLE_ENCODER_DEFINES_SVH
`define QUOTED_PRINTABLE_ENCODER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define QPE_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the trigger
`define QPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/qpe_pkg.sv
`timescale 1ns / 1ps

package qpe_pkg;

    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] LIMIT_RESET = 8'd76;

    // output positions of one token run, in emit order
    typedef enum logic [2:0] {
        STEP_SOFT_EQ,
        STEP_SOFT_CR,
        STEP_SOFT_LF,
        STEP_TOKEN,
        STEP_HEX_HI,
        STEP_HEX_LO,
        STEP_HARD_CR,
        STEP_HARD_LF
    } qpe_step_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       soft_brk;
        logic       escape;
        logic       crlf;
        logic       eom;
    } qpe_cmd_t;

    function automatic logic [7:0] qpe_step_mask(input qpe_cmd_t cmd);
        logic [7:0] m;
        m = 8'b0000_1000;
        if (cmd.soft_brk)
        begin
            m[2:0] = 3'b111;
        end
        if (cmd.escape)
        begin
            m[5:4] = 2'b11;
        end
        if (cmd.crlf)
        begin
            m[7:6] = 2'b11;
        end
        return m;
    endfunction

    function automatic qpe_step_t qpe_first_step(input logic [7:0] mask);
        qpe_step_t s;
        s = STEP_TOKEN;
        for (int i = 7; i >= 0; i--)
        begin
            if (mask[i])
            begin
                s = qpe_step_t'(3'(i));
            end
        end
        return s;
    endfunction

    function automatic qpe_step_t qpe_next_step(input logic [7:0] mask, input qpe_step_t cur);
        qpe_step_t s;
        s = cur;
        for (int i = 7; i >= 0; i--)
        begin
            if (mask[i] && (i > int'(cur)))
            begin
                s = qpe_step_t'(3'(i));
            end
        end
        return s;
    endfunction

    function automatic logic qpe_more_steps(input logic [7:0] mask, input qpe_step_t cur);
        logic more;
        more = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (mask[i] && (i > int'(cur)))
            begin
                more = 1'b1;
            end
        end
        return more;
    endfunction

    function automatic logic [7:0] qpe_hex(input logic [3:0] v);
        return (v < 4'd10) ? (8'd48 + {4'd0, v}) : (8'd55 + {4'd0, v});
    endfunction

endpackage

>>> design/quoted_printable_encoder.sv
`timescale 1ns / 1ps

// channel   | direction | transfer holds
// ----------+-----------+-------------------------------------------------
// s_*       | in        | tdata: data_byte[7:0]; tlast: end_of_message
// m_*       | out       | tdata: out_char[7:0]; tuser: last_of_run;
//           |           | tlast: message_done
// cfg_wr_*  | in        | line_limit[7:0], written when cfg_wr_en is high
//
// one input byte yields 1 to 8 output characters, one per cycle; the back
// end's character sequencer sets the rate, so a plain byte with no break
// flows at one transfer per cycle while m_tready stays high
// the front end classifies a byte in the cycle it is taken and tracks the
// line length, so s_tready only drops when the QUEUE_DEPTH entry queue fills
// reset clears line length, the pending-CR flag, the queue and the output
// register's valid flag, and sets line_limit to 76

module quoted_printable_encoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,   // line_limit[7:0]

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // data_byte[7:0]
    input  logic       s_tlast,       // end_of_message

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // out_char[7:0]
    output logic       m_tlast,       // message_done
    output logic [0:0] m_tuser        // last_of_run
);

    // classified byte from front end into the queue
    logic              q_push;
    logic              q_full;
    qpe_pkg::qpe_cmd_t q_wdata;

    // queue head toward the back end
    logic              q_pop;
    logic              q_valid;
    qpe_pkg::qpe_cmd_t q_rdata;

    // front end: escape test, soft break decision, CR LF pairing, line count
    qpe_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    // decouples classification from character output
    qpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    // back end: steps through soft break, token, hard break into the output register
    qpe_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> design/qpe_front.sv
`timescale 1ns / 1ps

module qpe_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             q_full,
    output logic             q_push,
    output qpe_pkg::qpe_cmd_t q_wdata
);

    logic [7:0] line_limit_reg;
    logic [7:0] line_len_reg;
    logic [7:0] line_len_next;
    logic       prev_cr_reg;
    logic       prev_cr_next;

    logic       escape;
    logic [8:0] tok_len;
    logic [8:0] sum;
    logic       soft_brk;
    logic       pair;
    logic [8:0] grown;

    always_comb
    begin
        escape   = (s_tdata < qpe_pkg::CH_SPACE) || (s_tdata == qpe_pkg::CH_EQ)
                   || (s_tdata > qpe_pkg::CH_TILDE);
        tok_len  = escape ? 9'd3 : 9'd1;
        sum      = {1'b0, line_len_reg} + tok_len;
        soft_brk = (line_len_reg != 8'd0) && (sum >= {1'b0, line_limit_reg});
        pair     = prev_cr_reg && (s_tdata == qpe_pkg::CH_LF);
        grown    = (soft_brk ? 9'd0 : {1'b0, line_len_reg}) + tok_len;

        s_tready = !q_full;
        q_push   = s_tvalid && !q_full;

        q_wdata.data_byte = s_tdata;
        q_wdata.soft_brk  = soft_brk;
        q_wdata.escape    = escape;
        q_wdata.crlf      = pair || s_tlast;
        q_wdata.eom       = s_tlast;

        line_len_next = line_len_reg;
        prev_cr_next  = prev_cr_reg;
        if (q_push)
        begin
            line_len_next = (pair || s_tlast) ? 8'd0 : grown[7:0];
            prev_cr_next  = !s_tlast && !pair && (s_tdata == qpe_pkg::CH_CR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= qpe_pkg::LIMIT_RESET;
            line_len_reg   <= 8'd0;
            prev_cr_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                line_limit_reg <= cfg_wr_data;
            end
            line_len_reg <= line_len_next;
            prev_cr_reg  <= prev_cr_next;
        end
    end

endmodule

>>> design/qpe_fifo.sv
`timescale 1ns / 1ps
`include "quoted_printable_encoder_defines.svh"

module qpe_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qpe_pkg::qpe_cmd_t wdata,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output qpe_pkg::qpe_cmd_t rdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qpe_pkg::qpe_cmd_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        full  = (count_reg == CNT_W'(DEPTH));
        valid = (count_reg != '0);
        rdata = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `QPE_ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, full, !push, "push into full queue")
    `QPE_ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst_n, !valid, !pop, "pop from empty queue")
    `QPE_ASSERT_IMPLIES(a_cnt_max, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "count overflow")

endmodule

>>> design/qpe_back.sv
`timescale 1ns / 1ps
`include "quoted_printable_encoder_defines.svh"

module qpe_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  qpe_pkg::qpe_cmd_t q_rdata,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [0:0]        m_tuser
);

    qpe_pkg::qpe_cmd_t  cmd_reg;
    qpe_pkg::qpe_cmd_t  cmd_next;
    logic               cmd_valid_reg;
    logic               cmd_valid_next;
    qpe_pkg::qpe_step_t step_reg;
    qpe_pkg::qpe_step_t step_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic [7:0] out_data_next;
    logic       out_run_reg;
    logic       out_run_next;
    logic       out_done_reg;
    logic       out_done_next;

    logic [7:0] mask;
    logic       is_last;
    logic       out_free;
    logic       emit;
    logic [7:0] cur_char;

    always_comb
    begin
        mask     = qpe_pkg::qpe_step_mask(cmd_reg);
        is_last  = !qpe_pkg::qpe_more_steps(mask, step_reg);
        out_free = !out_valid_reg || m_tready;
        emit     = cmd_valid_reg && out_free;
        q_pop    = q_valid && (!cmd_valid_reg || (emit && is_last));

        unique case (step_reg)
            qpe_pkg::STEP_SOFT_EQ: cur_char = qpe_pkg::CH_EQ;
            qpe_pkg::STEP_SOFT_CR: cur_char = qpe_pkg::CH_CR;
            qpe_pkg::STEP_SOFT_LF: cur_char = qpe_pkg::CH_LF;
            qpe_pkg::STEP_TOKEN:   cur_char = cmd_reg.escape ? qpe_pkg::CH_EQ : cmd_reg.data_byte;
            qpe_pkg::STEP_HEX_HI:  cur_char = qpe_pkg::qpe_hex(cmd_reg.data_byte[7:4]);
            qpe_pkg::STEP_HEX_LO:  cur_char = qpe_pkg::qpe_hex(cmd_reg.data_byte[3:0]);
            qpe_pkg::STEP_HARD_CR: cur_char = qpe_pkg::CH_CR;
            qpe_pkg::STEP_HARD_LF: cur_char = qpe_pkg::CH_LF;
            default:               cur_char = qpe_pkg::CH_EQ;
        endcase

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_run_next   = out_run_reg;
        out_done_next  = out_done_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = cur_char;
            out_run_next   = is_last;
            out_done_next  = is_last && cmd_reg.eom;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        step_next      = step_reg;
        if (emit && !is_last)
        begin
            step_next = qpe_pkg::qpe_next_step(mask, step_reg);
        end
        if (q_pop)
        begin
            cmd_next       = q_rdata;
            cmd_valid_next = 1'b1;
            step_next      = qpe_pkg::qpe_first_step(qpe_pkg::qpe_step_mask(q_rdata));
        end
        else if (emit && is_last)
        begin
            cmd_valid_next = 1'b0;
        end

        m_tvalid   = out_valid_reg;
        m_tdata    = out_data_reg;
        m_tlast    = out_done_reg;
        m_tuser[0] = out_run_reg;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
        out_run_reg  <= out_run_next;
        out_done_reg <= out_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            step_reg      <= qpe_pkg::STEP_TOKEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `QPE_ASSERT_IMPLIES(a_done_on_run_end, clk, rst_n, out_valid_reg && out_done_reg, out_run_reg, "message end not on run end")
    `QPE_ASSERT_IMPLIES(a_step_in_mask, clk, rst_n, cmd_valid_reg, mask[step_reg], "step outside the run")
    `QPE_ASSERT_NEXT(a_pop_loads_cmd, clk, rst_n, q_pop, cmd_valid_reg, "popped command not held")

endmodule
